// ----- hw/rtl/alarm_buzzer_pattern_sequencer_core_defines.svh -----
// Assertion macros for the alarm buzzer pattern sequencer.
// Used by the RTL files that carry concurrent assertions; expects clock and reset in scope.
`ifndef ALARM_BUZZER_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define ALARM_BUZZER_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Checked only outside reset.
`define ABPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every edge, reset included.
`define ABPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- hw/rtl/abps_pkg.sv -----
// Shared types and constants for the alarm buzzer pattern sequencer.
// No dependencies; used by the interfaces, abps_next and the top level.
`default_nettype none

package abps_pkg;

   localparam int TIME_BITS   = 24;
   localparam int OP_W        = 2;
   localparam int PATTERN_W   = 3;
   localparam int DURATION_W  = 24;
   localparam int TOGGLE_W    = 8;
   localparam int DUR_EXT_W   = (TIME_BITS > DURATION_W) ? TIME_BITS : DURATION_W;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_TRIGGER = 2'd1,
      OP_STOP    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [PATTERN_W-1:0] PAT_OFF          = 3'd0;
   localparam logic [PATTERN_W-1:0] PAT_CONTINUOUS   = 3'd1;
   localparam logic [PATTERN_W-1:0] PAT_SIREN        = 3'd2;
   localparam logic [PATTERN_W-1:0] PAT_PULSE        = 3'd3;
   localparam logic [PATTERN_W-1:0] PAT_ARM_CHIRP    = 3'd4;
   localparam logic [PATTERN_W-1:0] PAT_DISARM_CHIRP = 3'd5;
   localparam logic [PATTERN_W-1:0] PAT_UNKNOWN_LO   = 3'd6;
   localparam logic [PATTERN_W-1:0] PAT_UNKNOWN_HI   = 3'd7;

   localparam logic [TOGGLE_W-1:0] SIREN_ON_MS  = 8'd70;
   localparam logic [TOGGLE_W-1:0] SIREN_OFF_MS = 8'd30;
   localparam logic [TOGGLE_W-1:0] PULSE_ON_MS  = 8'd150;
   localparam logic [TOGGLE_W-1:0] PULSE_OFF_MS = 8'd50;

   localparam logic [TIME_BITS-1:0] ARM_CHIRP_MS     = TIME_BITS'(150);
   localparam logic [TIME_BITS-1:0] DISARM_FIRST_MS  = TIME_BITS'(80);
   localparam logic [TIME_BITS-1:0] DISARM_GAP_MS    = TIME_BITS'(160);
   localparam logic [TIME_BITS-1:0] DISARM_SECOND_MS = TIME_BITS'(240);

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic                 level;
      logic [TIME_BITS-1:0] since_trigger;
      logic [TOGGLE_W-1:0]  since_toggle;
      logic [TIME_BITS-1:0] limit;
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/abps_if.sv -----
// Valid/ready channel interfaces for requests and responses of the buzzer sequencer.
// Depends on abps_pkg for the field widths.
`default_nettype none

interface abps_req_if;
   import abps_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       operation;
   logic [PATTERN_W-1:0]  pattern;
   logic [DURATION_W-1:0] duration_ms;

   modport source (output valid, output operation, output pattern, output duration_ms,
                   input ready);
   modport sink (input valid, input operation, input pattern, input duration_ms,
                 output ready);
endinterface

interface abps_rsp_if;
   import abps_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 buzzer_on;
   logic                 active;
   logic [PATTERN_W-1:0] current_pattern;

   modport source (output valid, output buzzer_on, output active, output current_pattern,
                   input ready);
   modport sink (input valid, input buzzer_on, input active, input current_pattern,
                 output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/alarm_buzzer_pattern_sequencer_core.sv -----
// Alarm buzzer pattern sequencer, top level. Depends on abps_pkg, abps_if, abps_next and the
// defines header. Each request is a 1 ms tick, a trigger (pattern and duration in ms, zero for
// no limit), a stop or a no-op, and produces exactly one response with the buzzer level, the
// active flag and the held pattern after that request. Throughput is one request per clock
// while the response side does not stall. A request transfer loads the request register, and
// when the staged request moves on, a single pass of the next-state logic loads the response
// register, which raises response valid. The response register lets a new request be taken
// while the previous response still waits for its transfer.
`default_nettype none

`include "alarm_buzzer_pattern_sequencer_core_defines.svh"

module alarm_buzzer_pattern_sequencer_core (
   input  logic       clock,
   input  logic       reset,
   abps_req_if.sink   req_chan,
   abps_rsp_if.source rsp_chan
);
   import abps_pkg::*;

   logic                  stage_valid_ff;
   logic                  stage_valid_in;
   op_type                stage_op_ff;
   logic [PATTERN_W-1:0]  stage_pattern_ff;
   logic [DURATION_W-1:0] stage_duration_ff;

   state_type             state_ff;
   state_type             state_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_buzzer_ff;
   logic [PATTERN_W-1:0]  rsp_pattern_ff;

   logic                  stage_adv;
   logic                  req_xfer;

   // The staged request moves on when the response register is free or being drained.
   assign stage_adv = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || stage_adv;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign stage_valid_in = req_xfer || (stage_valid_ff && !stage_adv);
   assign rsp_valid_in   = stage_adv || (rsp_valid_ff && !rsp_chan.ready);

   abps_next u_next (
      .cur         (state_ff),
      .op          (stage_op_ff),
      .pattern     (stage_pattern_ff),
      .duration_ms (stage_duration_ff),
      .nxt         (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (stage_adv) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stage_op_ff       <= op_type'(req_chan.operation);
         stage_pattern_ff  <= req_chan.pattern;
         stage_duration_ff <= req_chan.duration_ms;
      end
      if (stage_adv) begin
         rsp_buzzer_ff  <= state_in.level;
         rsp_pattern_ff <= state_in.pattern;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.buzzer_on       = rsp_buzzer_ff;
   assign rsp_chan.active          = (rsp_pattern_ff != PAT_OFF);
   assign rsp_chan.current_pattern = rsp_pattern_ff;

   `ABPS_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid_ff, "Response valid right after reset")
   `ABPS_ASSERT(a_off_is_silent, (state_ff.pattern == PAT_OFF) |-> !state_ff.level, "Buzzer sounding while the alarm is off")
   `ABPS_ASSERT(a_limit_respected, (state_ff.limit != '0 && state_ff.pattern != PAT_OFF) |-> (state_ff.since_trigger < state_ff.limit), "Alarm still active past its duration")
   `ABPS_ASSERT(a_unknown_cleared, (stage_adv && stage_op_ff == OP_TICK) |=> (state_ff.pattern != PAT_UNKNOWN_LO && state_ff.pattern != PAT_UNKNOWN_HI), "Unknown pattern survived a tick")
   `ABPS_ASSERT(a_state_holds, !stage_adv |=> $stable(state_ff), "State changed without a staged request moving on")

endmodule

`default_nettype wire

// ----- hw/rtl/abps_next.sv -----
// Next-state logic of the buzzer sequencer: applies one tick, trigger or stop to the state.
// Depends on abps_pkg.
`default_nettype none

module abps_next (
   input  abps_pkg::state_type                  cur,
   input  abps_pkg::op_type                     op,
   input  logic [abps_pkg::PATTERN_W-1:0]       pattern,
   input  logic [abps_pkg::DURATION_W-1:0]      duration_ms,
   output abps_pkg::state_type                  nxt
);
   import abps_pkg::*;

   logic [TIME_BITS-1:0] trig_inc;
   logic [TOGGLE_W-1:0]  tog_inc;
   logic [TOGGLE_W-1:0]  on_ms;
   logic [TOGGLE_W-1:0]  off_ms;
   logic [DUR_EXT_W-1:0] dur_ext;
   logic [TIME_BITS-1:0] dur_sat;
   logic                 limit_hit;

   // Both elapsed counters saturate at all ones.
   assign trig_inc  = (&cur.since_trigger) ? cur.since_trigger : cur.since_trigger + 1'b1;
   assign tog_inc   = (&cur.since_toggle) ? cur.since_toggle : cur.since_toggle + 1'b1;
   assign limit_hit = (cur.limit != '0) && (trig_inc >= cur.limit);

   assign on_ms  = (cur.pattern == PAT_SIREN) ? SIREN_ON_MS : PULSE_ON_MS;
   assign off_ms = (cur.pattern == PAT_SIREN) ? SIREN_OFF_MS : PULSE_OFF_MS;

   assign dur_ext = DUR_EXT_W'(duration_ms);
   assign dur_sat = (dur_ext > DUR_EXT_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                            : dur_ext[TIME_BITS-1:0];

   always_comb begin
      nxt = cur;
      unique case (op)
         OP_TICK: begin
            if (cur.pattern != PAT_OFF) begin
               nxt.since_trigger = trig_inc;
               nxt.since_toggle  = tog_inc;
               if (limit_hit) begin
                  nxt.pattern = PAT_OFF;
                  nxt.level   = 1'b0;
               end else begin
                  unique case (cur.pattern)
                     PAT_CONTINUOUS: begin
                        nxt.level = cur.level;
                     end
                     PAT_SIREN, PAT_PULSE: begin
                        if ((cur.level && tog_inc >= on_ms) ||
                            (!cur.level && tog_inc >= off_ms)) begin
                           nxt.level        = !cur.level;
                           nxt.since_toggle = '0;
                        end
                     end
                     PAT_ARM_CHIRP: begin
                        if (trig_inc < ARM_CHIRP_MS) begin
                           nxt.level = 1'b1;
                        end else begin
                           nxt.pattern = PAT_OFF;
                           nxt.level   = 1'b0;
                        end
                     end
                     PAT_DISARM_CHIRP: begin
                        if (trig_inc < DISARM_FIRST_MS) begin
                           nxt.level = 1'b1;
                        end else if (trig_inc < DISARM_GAP_MS) begin
                           nxt.level = 1'b0;
                        end else if (trig_inc < DISARM_SECOND_MS) begin
                           nxt.level = 1'b1;
                        end else begin
                           nxt.pattern = PAT_OFF;
                           nxt.level   = 1'b0;
                        end
                     end
                     default: begin
                        // Unknown codes stop the alarm at their first tick.
                        nxt.pattern = PAT_OFF;
                        nxt.level   = 1'b0;
                     end
                  endcase
               end
            end
         end
         OP_TRIGGER: begin
            nxt.pattern       = pattern;
            nxt.since_trigger = '0;
            nxt.since_toggle  = '0;
            nxt.limit         = dur_sat;
            // Other patterns keep the old level until their first tick.
            if (pattern == PAT_CONTINUOUS) begin
               nxt.level = 1'b1;
            end else if (pattern == PAT_OFF) begin
               nxt.level = 1'b0;
            end
         end
         OP_STOP: begin
            nxt.pattern = PAT_OFF;
            nxt.level   = 1'b0;
         end
         OP_NONE: begin
            nxt = cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- test/tb_alarm_buzzer_pattern_sequencer_core.sv -----
// Self-checking testbench for the alarm buzzer pattern sequencer core.
// Depends on abps_pkg, the abps_req_if/abps_rsp_if interfaces and the core RTL.
`timescale 1ns / 100ps

module tb_alarm_buzzer_pattern_sequencer_core;
   import abps_pkg::*;

   localparam int ITEM_TARGET   = 1600;
   localparam int QUIET_TAIL    = 200;
   localparam int HOLD_AFTER    = 400;
   localparam int HOLD_CYCLES   = 80;
   localparam logic [TIME_BITS-1:0] TIME_FULL   = '1;
   localparam logic [TOGGLE_W-1:0]  TOGGLE_FULL = '1;

   typedef struct {
      op_type                op;
      logic [PATTERN_W-1:0]  pattern;
      logic [DURATION_W-1:0] duration;
   } buzzer_req_type;

   typedef struct packed {
      logic                 buzzer_on;
      logic                 active;
      logic [PATTERN_W-1:0] current_pattern;
   } buzzer_state_type;

   logic clock;
   logic reset;

   abps_req_if req_if ();
   abps_rsp_if rsp_if ();

   alarm_buzzer_pattern_sequencer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   buzzer_req_type   pending_requests[$];
   buzzer_state_type expected_states[$];

   // Predicted sequencer state.
   logic [PATTERN_W-1:0] alarm_pattern    = PAT_OFF;
   logic                 alarm_level      = 1'b0;
   logic [TIME_BITS-1:0] ms_since_trigger = '0;
   logic [TOGGLE_W-1:0]  ms_since_toggle  = '0;
   logic [TIME_BITS-1:0] alarm_limit      = '0;

   int  failures        = 0;
   int  requests_taken  = 0;
   int  responses_seen  = 0;
   int  ticks_taken     = 0;
   int  stops_taken     = 0;
   int  ignored_taken   = 0;
   int  sounding_seen   = 0;
   int  triggers_by_pattern[8];
   int  queued_items    = 0;
   int  send_gap        = 0;
   int  stall_left      = 0;
   logic rsp_hold       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[alarm_buzzer_pattern_sequencer_core] ERROR");
      $finish;
   end

   task automatic silence_alarm();
      alarm_pattern = PAT_OFF;
      alarm_level   = 1'b0;
   endtask

   task automatic toggle_level(input logic [TOGGLE_W-1:0] on_ms,
                               input logic [TOGGLE_W-1:0] off_ms);
      if (alarm_level && ms_since_toggle >= on_ms) begin
         alarm_level     = 1'b0;
         ms_since_toggle = '0;
      end else if (!alarm_level && ms_since_toggle >= off_ms) begin
         alarm_level     = 1'b1;
         ms_since_toggle = '0;
      end
   endtask

   task automatic advance_one_ms();
      if (alarm_pattern != PAT_OFF) begin
         if (ms_since_trigger != TIME_FULL) ms_since_trigger++;
         if (ms_since_toggle != TOGGLE_FULL) ms_since_toggle++;
         if (alarm_limit != '0 && ms_since_trigger >= alarm_limit) begin
            silence_alarm();
         end else begin
            case (alarm_pattern)
               PAT_CONTINUOUS: ;
               PAT_SIREN: toggle_level(SIREN_ON_MS, SIREN_OFF_MS);
               PAT_PULSE: toggle_level(PULSE_ON_MS, PULSE_OFF_MS);
               PAT_ARM_CHIRP: begin
                  if (ms_since_trigger < ARM_CHIRP_MS) alarm_level = 1'b1;
                  else silence_alarm();
               end
               PAT_DISARM_CHIRP: begin
                  if (ms_since_trigger < DISARM_FIRST_MS) alarm_level = 1'b1;
                  else if (ms_since_trigger < DISARM_GAP_MS) alarm_level = 1'b0;
                  else if (ms_since_trigger < DISARM_SECOND_MS) alarm_level = 1'b1;
                  else silence_alarm();
               end
               default: silence_alarm();
            endcase
         end
      end
   endtask

   // Updates the predicted state for one accepted request and queues the response it yields.
   task automatic predict_buzzer(input op_type op, input logic [PATTERN_W-1:0] pat,
                                 input logic [DURATION_W-1:0] dur);
      buzzer_state_type next_state;
      case (op)
         OP_TICK: begin
            advance_one_ms();
            ticks_taken++;
         end
         OP_TRIGGER: begin
            alarm_pattern    = pat;
            ms_since_trigger = '0;
            ms_since_toggle  = '0;
            if (DUR_EXT_W'(dur) > DUR_EXT_W'(TIME_FULL)) alarm_limit = TIME_FULL;
            else alarm_limit = TIME_BITS'(dur);
            if (pat == PAT_CONTINUOUS) alarm_level = 1'b1;
            else if (pat == PAT_OFF) silence_alarm();
            triggers_by_pattern[pat]++;
         end
         OP_STOP: begin
            silence_alarm();
            stops_taken++;
         end
         default: ignored_taken++;
      endcase
      next_state.buzzer_on       = alarm_level;
      next_state.active          = (alarm_pattern != PAT_OFF);
      next_state.current_pattern = alarm_pattern;
      expected_states.push_back(next_state);
   endtask

   task automatic queue_request(input op_type op, input logic [PATTERN_W-1:0] pat,
                                input logic [DURATION_W-1:0] dur);
      buzzer_req_type item;
      item.op       = op;
      item.pattern  = pat;
      item.duration = dur;
      pending_requests.push_back(item);
      if (op != OP_NONE) queued_items++;
   endtask

   task automatic queue_noise();
      queue_request(op_type'($urandom_range(0, 3)), PATTERN_W'($urandom_range(0, 7)),
                    DURATION_W'($urandom()));
   endtask

   task automatic build_stimulus();
      int                    run_len;
      int                    pick;
      logic [PATTERN_W-1:0]  pat;
      logic [DURATION_W-1:0] dur;
      // Directed corner cases: idle behavior, every pattern code, limits, retrigger.
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_NONE, PAT_UNKNOWN_HI, '1);
      queue_request(OP_STOP, PAT_OFF, '0);
      queue_request(OP_TRIGGER, PAT_CONTINUOUS, '0);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_NONE, PAT_SIREN, 24'd5);
      queue_request(OP_TRIGGER, PAT_OFF, '1);
      queue_request(OP_TRIGGER, PAT_UNKNOWN_LO, 24'd5);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_TRIGGER, PAT_UNKNOWN_HI, '0);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_TRIGGER, PAT_SIREN, 24'd1);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_TRIGGER, PAT_PULSE, '0);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_STOP, PAT_UNKNOWN_HI, '1);
      queue_request(OP_TRIGGER, PAT_ARM_CHIRP, '1);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_TRIGGER, PAT_DISARM_CHIRP, 24'd2);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_TICK, PAT_OFF, '0);
      // A trigger of a toggling pattern keeps the level until the next tick.
      queue_request(OP_TRIGGER, PAT_CONTINUOUS, 24'h555555);
      queue_request(OP_TRIGGER, PAT_SIREN, 24'hAAAAAA);
      queue_request(OP_TICK, PAT_OFF, '0);
      queue_request(OP_STOP, PAT_OFF, '0);

      // Mostly a trigger followed by a run of ticks, some noise mixed in.
      while (queued_items < ITEM_TARGET) begin
         if ($urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, 11);
            if (pick < 10) pat = PAT_CONTINUOUS + PATTERN_W'(pick % 5);
            else pat = PATTERN_W'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            if (pick < 4) dur = '0;
            else if (pick < 7) dur = DURATION_W'($urandom_range(1, 300));
            else dur = DURATION_W'($urandom());
            queue_request(OP_TRIGGER, pat, dur);
            if ($urandom_range(0, 1) == 0) run_len = $urandom_range(1, 40);
            else run_len = $urandom_range(100, 260);
            for (int i = 0; i < run_len; i++) begin
               if ($urandom_range(0, 99) < 3) queue_noise();
               else queue_request(OP_TICK, PATTERN_W'($urandom_range(0, 7)),
                                  DURATION_W'($urandom()));
            end
         end else begin
            run_len = $urandom_range(1, 4);
            for (int i = 0; i < run_len; i++) queue_noise();
         end
      end
   endtask

   function automatic bit idling_allowed(input int progress);
      return pending_requests.size() > QUIET_TAIL && (progress / 150) % 4 != 0;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      buzzer_req_type item;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap     <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap     <= send_gap - 1;
         end else if (pending_requests.size() > 0) begin
            item = pending_requests.pop_front();
            req_if.valid       <= 1'b1;
            req_if.operation   <= item.op;
            req_if.pattern     <= item.pattern;
            req_if.duration_ms <= item.duration;
            if (idling_allowed(pending_requests.size()) && $urandom_range(0, 7) == 0)
               send_gap <= $urandom_range(1, 10);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response receiver with random stall bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (rsp_hold) begin
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (idling_allowed(responses_seen + 75) && $urandom_range(0, 7) == 0)
            stall_left <= $urandom_range(1, 10);
      end
   end

   // One long hold-off on the response side so the core backs up and stalls its input.
   initial begin
      wait (requests_taken >= HOLD_AFTER);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Monitor: checks each response transfer, then predicts from each request transfer.
   always @(posedge clock) begin
      buzzer_state_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            responses_seen++;
            if (rsp_if.buzzer_on) sounding_seen++;
            if (expected_states.size() == 0) begin
               $error("response transfer with no response expected");
               failures++;
            end else begin
               want = expected_states.pop_front();
               if (rsp_if.buzzer_on !== want.buzzer_on) begin
                  $error("buzzer_on: expected %0d, actual %0d", want.buzzer_on,
                         rsp_if.buzzer_on);
                  failures++;
               end
               if (rsp_if.active !== want.active) begin
                  $error("active: expected %0d, actual %0d", want.active, rsp_if.active);
                  failures++;
               end
               if (rsp_if.current_pattern !== want.current_pattern) begin
                  $error("current_pattern: expected %0d, actual %0d", want.current_pattern,
                         rsp_if.current_pattern);
                  failures++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            requests_taken++;
            predict_buzzer(op_type'(req_if.operation), req_if.pattern, req_if.duration_ms);
         end
      end
   end

   initial begin
      reset = 1'b1;
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_states.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Run covered %0d requests: %0d ticks, %0d stops, %0d ignored; %0d responses checked, %0d with the buzzer sounding.",
               requests_taken, ticks_taken, stops_taken, ignored_taken, responses_seen,
               sounding_seen);
      $display("Triggers per pattern code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
               triggers_by_pattern[0], triggers_by_pattern[1], triggers_by_pattern[2],
               triggers_by_pattern[3], triggers_by_pattern[4], triggers_by_pattern[5],
               triggers_by_pattern[6], triggers_by_pattern[7]);
      if (failures == 0) begin
         $display("[alarm_buzzer_pattern_sequencer_core] OK");
      end else begin
         $display("[alarm_buzzer_pattern_sequencer_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/abps_pkg.sv
hw/rtl/abps_if.sv
hw/rtl/abps_next.sv
hw/rtl/alarm_buzzer_pattern_sequencer_core.sv
test/tb_alarm_buzzer_pattern_sequencer_core.sv
